>>> hdl/sad32_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SAD32 package
// Shared widths, constants, codes and types for the candidate minimum tracker.
// ----------------------------------------------------------------------------
package sad32_pkg;

   // Pixel geometry of one half-row word
   localparam int PIX_W        = 8;
   localparam int PIX_COUNT    = 16;
   localparam int PIX_BUS_W    = PIX_W * PIX_COUNT;
   localparam int ITEM_SAD_W   = 12;

   // Quadrant height in rows; rows at or above it belong to the bottom quadrants.
   localparam int QUAD_SIZE    = 16;
   localparam int ROW_CMP_W    = 6;

   localparam int VEC_W        = 11;
   localparam int DIR_W        = 4;
   localparam int SEG_W        = 6;
   localparam int ENTRY_W      = 3;
   localparam int QSUM_W       = 17;
   localparam int TOTAL_W      = 19;
   localparam int SAD_W        = 21;
   localparam int NUM_QUADS    = 4;
   localparam int NUM_ENTRIES  = 5;

   localparam logic [SEG_W-1:0]   LAST_SEGMENT = 6'd63;
   localparam logic [QSUM_W-1:0]  QSUM_MAX     = 17'd131071;
   localparam logic [SAD_W-1:0]   SAD_INIT     = 21'(4096 * 256);

   localparam logic [ENTRY_W-1:0] ENTRY_WHOLE  = 3'd0;
   localparam logic [ENTRY_W-1:0] ENTRY_LAST   = 3'd4;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_VEC_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_VEC_X = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_VEC_Y = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_VEC_Y = 2'd3;

   // Stream word layouts
   localparam int REQ_DATA_W = 4 * 64 + 2 * VEC_W + DIR_W + SEG_W;
   localparam int RSP_FIELD_W = ENTRY_W + SAD_W + 2 * VEC_W + DIR_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FIELD_W;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic [SAD_W-1:0]        sad_type;
   typedef logic [QSUM_W-1:0]       qsum_type;
   typedef logic [ITEM_SAD_W-1:0]   item_sad_type;

   localparam vec_type VEC_LOW  = -11'sd1024;
   localparam vec_type VEC_HIGH = 11'sd1023;

endpackage

>>> hdl/sad32_candidate_min_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SAD32 candidate minimum tracker
// Accumulates 16x16 quadrant SADs of a 32x32 block and keeps the best vectors.
// ----------------------------------------------------------------------------
// Results: a candidate's last-segment word passes stages 1 to 3 and loads the
// result buffer; the five result words follow one per cycle while rsp_tready
// is high. Throughput: one request word per cycle. A last-segment word that
// reaches the update stage while earlier results are still queued holds the
// pipeline. Reset is synchronous and active high; it clears sums, minima,
// vectors, the direction, the range registers and all pipeline control state.
// ----------------------------------------------------------------------------
//
// The pipeline has three register stages, all moved by one shared advance
// signal:
//   stage 1 registers the request word;
//   stage 2 holds the sixteen-pixel SAD of the word;
//   stage 3 holds the final quadrant sums of a candidate (taken when the word
//           in stage 2 carries the last segment) together with its vector.
// The quadrant accumulators are updated as a word leaves stage 2, and the
// minima are updated as a word leaves stage 3. Every word passes stage 3, so
// a new-block flag resets the minima in order with the candidate updates.
// On a last-segment word the updated minima are copied into a five-entry
// result buffer, which is then drained one word per cycle on the rsp side
// while rsp_tready is high. The advance signal depends on registers only, so
// req_tready has no combinational path from rsp_tready.
module sad32_candidate_min_tracker #(
   // Quadrant height in rows; rows at or above it belong to the bottom quadrants.
   parameter int QUAD_SIZE = sad32_pkg::QUAD_SIZE
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // From bit 0: cur_pixels_lo, cur_pixels_hi, ref_pixels_lo, ref_pixels_hi,
   // cand_x, cand_y, direction, segment.
   input  logic [sad32_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Bit 0: new_block.
   input  logic                                  req_tuser,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // From bit 0: entry, min_sad, best_x, best_y, best_dir, zero padding.
   output logic [sad32_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Marks the fifth word of a candidate.
   output logic                                  rsp_tlast,

   input  logic                                  csr_we,
   input  logic [sad32_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [sad32_pkg::VEC_W-1:0]           csr_wdata
);

   localparam int VW = sad32_pkg::VEC_W;
   localparam int NQ = sad32_pkg::NUM_QUADS;
   localparam int NE = sad32_pkg::NUM_ENTRIES;

   // ------------------------------------------------------------------------
   // Range registers
   // ------------------------------------------------------------------------
   sad32_pkg::vec_type min_x_ff, max_x_ff, min_y_ff, max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= sad32_pkg::VEC_LOW;
         max_x_ff <= sad32_pkg::VEC_HIGH;
         min_y_ff <= sad32_pkg::VEC_LOW;
         max_y_ff <= sad32_pkg::VEC_HIGH;
      end else if (csr_we) begin
         case (csr_addr)
            sad32_pkg::CSR_MIN_VEC_X: min_x_ff <= csr_wdata;
            sad32_pkg::CSR_MAX_VEC_X: max_x_ff <= csr_wdata;
            sad32_pkg::CSR_MIN_VEC_Y: min_y_ff <= csr_wdata;
            sad32_pkg::CSR_MAX_VEC_Y: max_y_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s3_last_ff;
   logic ob_busy_ff;
   logic advance;

   // The only hold-up: a candidate is ready to be reported but the result
   // buffer is still draining the previous one.
   assign advance    = !(s3_valid_ff && s3_last_ff && ob_busy_ff);
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: request register
   // ------------------------------------------------------------------------
   logic [sad32_pkg::PIX_BUS_W-1:0] s1_cur_ff, s1_ref_ff;
   sad32_pkg::vec_type              s1_x_ff, s1_y_ff;
   logic [sad32_pkg::DIR_W-1:0]     s1_dir_ff;
   logic [sad32_pkg::SEG_W-1:0]     s1_seg_ff;
   logic                            s1_new_ff;

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         s1_cur_ff <= req_tdata[127:0];
         s1_ref_ff <= req_tdata[255:128];
         s1_x_ff   <= req_tdata[256 +: VW];
         s1_y_ff   <= req_tdata[256 + VW +: VW];
         s1_dir_ff <= req_tdata[256 + 2*VW +: sad32_pkg::DIR_W];
         s1_seg_ff <= req_tdata[256 + 2*VW + sad32_pkg::DIR_W +: sad32_pkg::SEG_W];
         s1_new_ff <= req_tuser;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: SAD of the sixteen pixel pairs
   // ------------------------------------------------------------------------
   sad32_pkg::item_sad_type     item_sad;
   sad32_pkg::item_sad_type     s2_sad_ff;
   sad32_pkg::vec_type          s2_x_ff, s2_y_ff;
   logic [sad32_pkg::DIR_W-1:0] s2_dir_ff;
   logic [sad32_pkg::SEG_W-1:0] s2_seg_ff;
   logic                        s2_new_ff;

   sad32_absdiff16 u_absdiff (
      .cur_pix (s1_cur_ff),
      .ref_pix (s1_ref_ff),
      .sad     (item_sad)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sad_ff <= item_sad;
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_dir_ff <= s1_dir_ff;
         s2_seg_ff <= s1_seg_ff;
         s2_new_ff <= s1_new_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Quadrant accumulation
   // ------------------------------------------------------------------------
   sad32_pkg::qsum_type qsum_ff  [NQ];
   sad32_pkg::qsum_type qsum_in  [NQ];
   sad32_pkg::qsum_type qsum_upd [NQ];
   logic [1:0]                  s2_quad;
   logic                        s2_last;
   logic [sad32_pkg::QSUM_W:0]  qsum_acc;
   sad32_pkg::qsum_type         qsum_sat;

   // Bit 1 selects the bottom half, bit 0 the right half.
   assign s2_quad = {({1'b0, s2_seg_ff[sad32_pkg::SEG_W-1:1]} >=
                      sad32_pkg::ROW_CMP_W'(QUAD_SIZE)),
                     s2_seg_ff[0]};
   assign s2_last = (s2_seg_ff == sad32_pkg::LAST_SEGMENT);

   always_comb begin
      qsum_acc = {1'b0, qsum_ff[s2_quad]} +
                 (sad32_pkg::QSUM_W + 1)'(s2_sad_ff);
      // A quadrant sum sticks at its maximum when repeated segments overflow it.
      if (qsum_acc > {1'b0, sad32_pkg::QSUM_MAX}) begin
         qsum_sat = sad32_pkg::QSUM_MAX;
      end else begin
         qsum_sat = qsum_acc[sad32_pkg::QSUM_W-1:0];
      end
      for (int i = 0; i < NQ; i++) begin
         qsum_upd[i] = (s2_quad == 2'(i)) ? qsum_sat : qsum_ff[i];
         if (s2_valid_ff && advance) begin
            qsum_in[i] = s2_last ? '0 : qsum_upd[i];
         end else begin
            qsum_in[i] = qsum_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            qsum_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NQ; i++) begin
            qsum_ff[i] <= qsum_in[i];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: final sums of a candidate
   // ------------------------------------------------------------------------
   sad32_pkg::qsum_type         s3_sums_ff [NQ];
   sad32_pkg::vec_type          s3_x_ff, s3_y_ff;
   logic [sad32_pkg::DIR_W-1:0] s3_dir_ff;
   logic                        s3_new_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_last_ff <= 1'b0;
      end else if (advance) begin
         s3_last_ff <= s2_last;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NQ; i++) begin
            s3_sums_ff[i] <= qsum_upd[i];
         end
         s3_x_ff   <= s2_x_ff;
         s3_y_ff   <= s2_y_ff;
         s3_dir_ff <= s2_dir_ff;
         s3_new_ff <= s2_new_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Minimum update
   // ------------------------------------------------------------------------
   sad32_pkg::sad_type          min_sad_ff [NE];
   sad32_pkg::vec_type          best_x_ff  [NE];
   sad32_pkg::vec_type          best_y_ff  [NE];
   logic [sad32_pkg::DIR_W-1:0] best_dir_ff;

   sad32_pkg::sad_type          base_sad   [NE];
   sad32_pkg::vec_type          base_x     [NE];
   sad32_pkg::vec_type          base_y     [NE];
   sad32_pkg::sad_type          cand_sad   [NE];
   sad32_pkg::sad_type          min_sad_in [NE];
   sad32_pkg::vec_type          best_x_in  [NE];
   sad32_pkg::vec_type          best_y_in  [NE];
   logic [sad32_pkg::DIR_W-1:0] best_dir_in;
   logic [sad32_pkg::TOTAL_W-1:0] total;
   logic                        in_range;
   logic                        s3_fire;
   logic                        ob_load;

   assign s3_fire = s3_valid_ff && advance;
   assign ob_load = s3_fire && s3_last_ff;

   // Inclusive bounds; an empty range lets no candidate through.
   assign in_range = (s3_x_ff >= min_x_ff) && (s3_x_ff <= max_x_ff) &&
                     (s3_y_ff >= min_y_ff) && (s3_y_ff <= max_y_ff);

   assign total = sad32_pkg::TOTAL_W'(s3_sums_ff[0]) + sad32_pkg::TOTAL_W'(s3_sums_ff[1]) +
                  sad32_pkg::TOTAL_W'(s3_sums_ff[2]) + sad32_pkg::TOTAL_W'(s3_sums_ff[3]);

   always_comb begin
      cand_sad[0] = sad32_pkg::SAD_W'(total);
      for (int i = 0; i < NQ; i++) begin
         cand_sad[i+1] = sad32_pkg::SAD_W'(s3_sums_ff[i]);
      end
      // A new block resets the minima ahead of this word's own update.
      for (int i = 0; i < NE; i++) begin
         base_sad[i] = s3_new_ff ? sad32_pkg::SAD_INIT : min_sad_ff[i];
         base_x[i]   = s3_new_ff ? '0 : best_x_ff[i];
         base_y[i]   = s3_new_ff ? '0 : best_y_ff[i];
      end
      best_dir_in = best_dir_ff;
      // Strictly smaller only: a tie keeps the earlier candidate.
      for (int i = 0; i < NE; i++) begin
         if (s3_last_ff && in_range && (cand_sad[i] < base_sad[i])) begin
            min_sad_in[i] = cand_sad[i];
            best_x_in[i]  = s3_x_ff;
            best_y_in[i]  = s3_y_ff;
         end else begin
            min_sad_in[i] = base_sad[i];
            best_x_in[i]  = base_x[i];
            best_y_in[i]  = base_y[i];
         end
      end
      if (s3_last_ff && in_range && (cand_sad[0] < base_sad[0])) begin
         best_dir_in = s3_dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NE; i++) begin
            min_sad_ff[i] <= sad32_pkg::SAD_INIT;
            best_x_ff[i]  <= '0;
            best_y_ff[i]  <= '0;
         end
         best_dir_ff <= '0;
      end else if (s3_fire) begin
         for (int i = 0; i < NE; i++) begin
            min_sad_ff[i] <= min_sad_in[i];
            best_x_ff[i]  <= best_x_in[i];
            best_y_ff[i]  <= best_y_in[i];
         end
         best_dir_ff <= best_dir_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result buffer: five words per candidate, drained in entry order
   // ------------------------------------------------------------------------
   sad32_pkg::sad_type            ob_sad_ff [NE];
   sad32_pkg::vec_type            ob_x_ff   [NE];
   sad32_pkg::vec_type            ob_y_ff   [NE];
   logic [sad32_pkg::DIR_W-1:0]   ob_dir_ff;
   logic [sad32_pkg::ENTRY_W-1:0] ob_cnt_ff;
   logic                          rsp_fire;
   logic [sad32_pkg::DIR_W-1:0]   out_dir;

   assign rsp_fire = ob_busy_ff && rsp_tready;

   // The entry counter returns to the whole-block entry after the fifth word,
   // so it always indexes a valid buffer entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         ob_busy_ff <= 1'b0;
         ob_cnt_ff  <= sad32_pkg::ENTRY_WHOLE;
      end else if (ob_load) begin
         ob_busy_ff <= 1'b1;
         ob_cnt_ff  <= sad32_pkg::ENTRY_WHOLE;
      end else if (rsp_fire) begin
         if (ob_cnt_ff == sad32_pkg::ENTRY_LAST) begin
            ob_busy_ff <= 1'b0;
            ob_cnt_ff  <= sad32_pkg::ENTRY_WHOLE;
         end else begin
            ob_cnt_ff <= ob_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ob_load) begin
         for (int i = 0; i < NE; i++) begin
            ob_sad_ff[i] <= min_sad_in[i];
            ob_x_ff[i]   <= best_x_in[i];
            ob_y_ff[i]   <= best_y_in[i];
         end
         ob_dir_ff <= best_dir_in;
      end
   end

   // The direction belongs to the whole-block entry only.
   assign out_dir = (ob_cnt_ff == sad32_pkg::ENTRY_WHOLE) ? ob_dir_ff : '0;

   assign rsp_tvalid = ob_busy_ff;
   assign rsp_tlast  = (ob_cnt_ff == sad32_pkg::ENTRY_LAST);
   assign rsp_tdata  = {{sad32_pkg::RSP_PAD_W{1'b0}}, out_dir,
                        ob_y_ff[ob_cnt_ff], ob_x_ff[ob_cnt_ff],
                        ob_sad_ff[ob_cnt_ff], ob_cnt_ff};

endmodule

>>> hdl/sad32_absdiff16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SAD32 sixteen-pixel absolute difference sum
// Sums the absolute differences of sixteen byte pairs through an adder tree.
// ----------------------------------------------------------------------------
module sad32_absdiff16 (
   input  logic [sad32_pkg::PIX_BUS_W-1:0] cur_pix,
   input  logic [sad32_pkg::PIX_BUS_W-1:0] ref_pix,
   output sad32_pkg::item_sad_type         sad
);

   logic [7:0]  diff [16];
   logic [8:0]  lvl1 [8];
   logic [9:0]  lvl2 [4];
   logic [10:0] lvl3 [2];

   always_comb begin
      for (int i = 0; i < sad32_pkg::PIX_COUNT; i++) begin
         if (cur_pix[i*8 +: 8] > ref_pix[i*8 +: 8]) begin
            diff[i] = cur_pix[i*8 +: 8] - ref_pix[i*8 +: 8];
         end else begin
            diff[i] = ref_pix[i*8 +: 8] - cur_pix[i*8 +: 8];
         end
      end
      for (int i = 0; i < 8; i++) begin
         lvl1[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
      end
   end

   assign sad = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};

endmodule

>>> tb/sad32_candidate_min_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SAD32 candidate minimum tracker testbench
// Streams half-row words of motion-search candidates into the tracker. An
// in-bench predictor models the quadrant sums, the range check and the kept
// minima. Every result word is checked against the predictor's next
// expectation. Sender gaps and receiver stalls are random.
// ----------------------------------------------------------------------------
module sad32_candidate_min_tracker_test;

   // A request word. new_block travels on tuser and the rest on tdata. The
   // member order makes {req_tuser, req_tdata} a plain copy of the struct.
   typedef struct packed {
      logic                        new_block;
      logic [sad32_pkg::SEG_W-1:0] segment;
      logic [sad32_pkg::DIR_W-1:0] direction;
      sad32_pkg::vec_type          cand_y;
      sad32_pkg::vec_type          cand_x;
      logic [63:0]                 ref_hi;
      logic [63:0]                 ref_lo;
      logic [63:0]                 cur_hi;
      logic [63:0]                 cur_lo;
   } req_word_type;

   // A result word. It is laid out as {rsp_tlast, tdata fields}.
   typedef struct packed {
      logic                          last;
      logic [sad32_pkg::DIR_W-1:0]   best_dir;
      sad32_pkg::vec_type            best_y;
      sad32_pkg::vec_type            best_x;
      sad32_pkg::sad_type            min_sad;
      logic [sad32_pkg::ENTRY_W-1:0] entry;
   } minima_word_type;

   typedef enum {
      CONTENT_RANDOM, CONTENT_EQUAL, CONTENT_NOISY, CONTENT_MAX_DIFF, CONTENT_CHECKER
   } content_kind_type;

   typedef enum { READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_SPARSE } ready_pattern_type;

   // Results trail the closing word through the pipeline. Allow some margin.
   localparam int PIPE_SETTLE    = 10;
   // The longest quiet stretch in a correct run is a short sender gap or a
   // receiver stall. This limit is far beyond either.
   localparam int WATCHDOG_LIMIT = 3000;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [sad32_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [sad32_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_we;
   logic [sad32_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [sad32_pkg::VEC_W-1:0]      csr_wdata;

   // Predicted tracker state, kept in step with the words that are accepted.
   int unsigned                 track_qsum    [sad32_pkg::NUM_QUADS];
   int unsigned                 track_min_sad [sad32_pkg::NUM_ENTRIES];
   sad32_pkg::vec_type          track_best_x  [sad32_pkg::NUM_ENTRIES];
   sad32_pkg::vec_type          track_best_y  [sad32_pkg::NUM_ENTRIES];
   logic [sad32_pkg::DIR_W-1:0] track_best_dir;
   sad32_pkg::vec_type          lim_min_x, lim_max_x, lim_min_y, lim_max_y;

   minima_word_type expected_minima[$];
   int              error_count = 0;
   int              burst_left  = 0;
   int              quiet_cycles = 0;

   sad32_candidate_min_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Sum of absolute differences over eight pixel pairs.
   function automatic int unsigned half_sad(logic [63:0] a, logic [63:0] b);
      int unsigned sum = 0;
      for (int i = 0; i < 8; i++)
         sum += (a[8*i +: 8] > b[8*i +: 8]) ? int'(a[8*i +: 8]) - int'(b[8*i +: 8])
                                             : int'(b[8*i +: 8]) - int'(a[8*i +: 8]);
      return sum;
   endfunction

   function automatic void clear_tracked_minima();
      for (int e = 0; e < sad32_pkg::NUM_ENTRIES; e++) begin
         track_min_sad[e] = sad32_pkg::SAD_INIT;
         track_best_x[e]  = '0;
         track_best_y[e]  = '0;
      end
   endfunction

   // Adds one accepted word to its quadrant. On the closing segment it
   // applies the range check and the strict less-than updates, and then
   // queues the five minima that the block must report.
   function automatic void track_candidate_word(req_word_type w);
      int unsigned     quad;
      int unsigned     total;
      minima_word_type r;
      // The new-block flag acts before the word's own differences are added.
      // The direction of the old best survives it.
      if (w.new_block)
         clear_tracked_minima();
      quad = w.segment[0] + (((w.segment >> 1) >= sad32_pkg::QUAD_SIZE) ? 2 : 0);
      track_qsum[quad] += half_sad(w.cur_lo, w.ref_lo) + half_sad(w.cur_hi, w.ref_hi);
      if (track_qsum[quad] > sad32_pkg::QSUM_MAX)
         track_qsum[quad] = sad32_pkg::QSUM_MAX;
      if (w.segment != sad32_pkg::LAST_SEGMENT)
         return;
      if ($signed(w.cand_x) >= $signed(lim_min_x) && $signed(w.cand_x) <= $signed(lim_max_x) &&
          $signed(w.cand_y) >= $signed(lim_min_y) && $signed(w.cand_y) <= $signed(lim_max_y)) begin
         total = track_qsum[0] + track_qsum[1] + track_qsum[2] + track_qsum[3];
         if (total < track_min_sad[0]) begin
            track_min_sad[0] = total;
            track_best_x[0]  = w.cand_x;
            track_best_y[0]  = w.cand_y;
            track_best_dir   = w.direction;
         end
         for (int q = 0; q < sad32_pkg::NUM_QUADS; q++) begin
            if (track_qsum[q] < track_min_sad[q+1]) begin
               track_min_sad[q+1] = track_qsum[q];
               track_best_x[q+1]  = w.cand_x;
               track_best_y[q+1]  = w.cand_y;
            end
         end
      end
      // A candidate outside the range still reports and still clears its sums.
      for (int q = 0; q < sad32_pkg::NUM_QUADS; q++)
         track_qsum[q] = 0;
      for (int e = 0; e < sad32_pkg::NUM_ENTRIES; e++) begin
         r.entry    = sad32_pkg::ENTRY_W'(e);
         r.min_sad  = sad32_pkg::sad_type'(track_min_sad[e]);
         r.best_x   = track_best_x[e];
         r.best_y   = track_best_y[e];
         r.best_dir = (r.entry == sad32_pkg::ENTRY_WHOLE) ? track_best_dir : '0;
         r.last     = (r.entry == sad32_pkg::ENTRY_LAST);
         expected_minima.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: all handshakes are sampled at the rising edge. A result word is
   // checked before the request word of the same edge is predicted. A result
   // that appears too early is then reported as unexpected and does not
   // consume the new expectations.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : minima_monitor
      minima_word_type seen;
      minima_word_type want;
      if (reset) begin
         for (int q = 0; q < sad32_pkg::NUM_QUADS; q++)
            track_qsum[q] = 0;
         clear_tracked_minima();
         track_best_dir = '0;
         lim_min_x = sad32_pkg::VEC_LOW;
         lim_max_x = sad32_pkg::VEC_HIGH;
         lim_min_y = sad32_pkg::VEC_LOW;
         lim_max_y = sad32_pkg::VEC_HIGH;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tlast, rsp_tdata[sad32_pkg::RSP_FIELD_W-1:0]};
            if (expected_minima.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result word, entry %0d sad %0d",
                           $time, seen.entry, seen.min_sad);
            end else begin
               want = expected_minima.pop_front();
               if (seen !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%0t: result mismatch, expected entry %0d sad %0d vec %0d,%0d ",
                               "dir %0d last %0b, got entry %0d sad %0d vec %0d,%0d dir %0d last %0b"},
                              $time, want.entry, want.min_sad, $signed(want.best_x),
                              $signed(want.best_y), want.best_dir, want.last, seen.entry,
                              seen.min_sad, $signed(seen.best_x), $signed(seen.best_y),
                              seen.best_dir, seen.last);
               end
            end
         end
         if (csr_we) begin
            case (csr_addr)
               sad32_pkg::CSR_MIN_VEC_X: lim_min_x = sad32_pkg::vec_type'(csr_wdata);
               sad32_pkg::CSR_MAX_VEC_X: lim_max_x = sad32_pkg::vec_type'(csr_wdata);
               sad32_pkg::CSR_MIN_VEC_Y: lim_min_y = sad32_pkg::vec_type'(csr_wdata);
               sad32_pkg::CSR_MAX_VEC_Y: lim_max_y = sad32_pkg::vec_type'(csr_wdata);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            track_candidate_word({req_tuser, req_tdata});
      end
   end

   // The watchdog ends the run if no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver back-pressure. The pattern is redrawn whenever its random run
   // length runs out. It is always ready, randomly ready, ready when the tick
   // count is a multiple of three, or mostly stalled.
   initial begin : rsp_stall_pattern
      ready_pattern_type pattern;
      int                pattern_left;
      int                tick;
      rsp_tready   = 1'b0;
      pattern      = READY_ALWAYS;
      pattern_left = 0;
      tick         = 0;
      forever begin
         @(negedge clock);
         if (pattern_left == 0) begin
            pattern      = ready_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 96);
         end
         pattern_left--;
         tick++;
         case (pattern)
            READY_ALWAYS:   rsp_tready <= 1'b1;
            READY_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: rsp_tready <= (tick % 3 == 0);
            default:        rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic sad32_pkg::vec_type any_vec();
      return sad32_pkg::vec_type'($urandom_range(0, (1 << sad32_pkg::VEC_W) - 1));
   endfunction

   // A vector a few steps around an inclusive range. The steps outside the
   // range are also exercised. For an empty range, any vector will do.
   function automatic sad32_pkg::vec_type vec_near_range(int lo, int hi);
      int a;
      int b;
      if (lo > hi)
         return any_vec();
      a = (lo - 4 < int'(sad32_pkg::VEC_LOW)) ? int'(sad32_pkg::VEC_LOW) : lo - 4;
      b = (hi + 4 > int'(sad32_pkg::VEC_HIGH)) ? int'(sad32_pkg::VEC_HIGH) : hi + 4;
      return sad32_pkg::vec_type'(a + int'($urandom_range(0, b - a)));
   endfunction

   function automatic req_word_type make_word(logic [sad32_pkg::SEG_W-1:0] seg,
                                              sad32_pkg::vec_type cx, sad32_pkg::vec_type cy,
                                              logic [sad32_pkg::DIR_W-1:0] dir, logic nb,
                                              content_kind_type kind);
      req_word_type w;
      w.new_block = nb;
      w.segment   = seg;
      w.direction = dir;
      w.cand_x    = cx;
      w.cand_y    = cy;
      w.cur_lo    = {$urandom, $urandom};
      w.cur_hi    = {$urandom, $urandom};
      w.ref_lo    = {$urandom, $urandom};
      w.ref_hi    = {$urandom, $urandom};
      case (kind)
         CONTENT_EQUAL: begin
            w.ref_lo = w.cur_lo;
            w.ref_hi = w.cur_hi;
         end
         CONTENT_NOISY: begin
            // Small differences keep the sums low, so the minima keep moving.
            w.ref_lo = w.cur_lo ^ ({$urandom, $urandom} & {8{8'h07}});
            w.ref_hi = w.cur_hi ^ ({$urandom, $urandom} & {8{8'h07}});
         end
         CONTENT_MAX_DIFF: begin
            w.cur_lo = '1;
            w.cur_hi = '1;
            w.ref_lo = '0;
            w.ref_hi = '0;
         end
         CONTENT_CHECKER: begin
            w.cur_lo = {8{8'hAA}};
            w.cur_hi = {8{8'hAA}};
            w.ref_lo = {8{8'h55}};
            w.ref_hi = {8{8'h55}};
         end
         default: ;
      endcase
      return w;
   endfunction

   // Sends one request word. The sender runs in bursts of random length.
   // Between bursts it leaves random gaps. Valid stays high inside a burst.
   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      {req_tuser, req_tdata} <= w;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Holds the sender off until every expected result has been seen. It then
   // lets the pipeline empty out words that produce no result.
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_minima.size() != 0)
         @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [sad32_pkg::CSR_ADDR_W-1:0] index,
                            input sad32_pkg::vec_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Short candidates, most under the reset range: the field extremes, ties,
   // repeated and out-of-order segments, the new-block flag and a lower x bound.
   task automatic test_directed_cases();
      // The largest difference, all in the bottom-right quadrant, at the most
      // negative vector. The other quadrants score zero.
      send_word(make_word(sad32_pkg::LAST_SEGMENT, sad32_pkg::VEC_LOW, sad32_pkg::VEC_LOW,
                          4'hF, 1'b1, CONTENT_MAX_DIFF));
      // A perfect match at the most positive vector. The zero quadrants tie
      // with their stored zeros and must keep the old vector.
      send_word(make_word('0, sad32_pkg::VEC_HIGH, sad32_pkg::VEC_HIGH, 4'h0, 1'b0,
                          CONTENT_EQUAL));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, sad32_pkg::VEC_HIGH, sad32_pkg::VEC_HIGH,
                          4'h0, 1'b0, CONTENT_EQUAL));
      // An equal whole-block SAD does not replace the stored best.
      send_word(make_word(sad32_pkg::LAST_SEGMENT, 11'sd5, -11'sd5, 4'h9, 1'b0, CONTENT_EQUAL));
      // Segments out of order and one repeated. 62 and 32 fall in the bottom
      // left quadrant, and 1 falls in the top right one.
      send_word(make_word(6'd62, any_vec(), any_vec(), 4'h3, 1'b1, CONTENT_RANDOM));
      send_word(make_word(6'd1, any_vec(), any_vec(), 4'h3, 1'b0, CONTENT_CHECKER));
      send_word(make_word(6'd1, any_vec(), any_vec(), 4'h3, 1'b0, CONTENT_CHECKER));
      send_word(make_word(6'd32, any_vec(), any_vec(), 4'h3, 1'b0, CONTENT_NOISY));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, any_vec(), any_vec(), 4'h6, 1'b0,
                          CONTENT_RANDOM));
      // A new-block flag on the closing word clears the minima, but not the
      // sums already gathered.
      send_word(make_word(6'd5, any_vec(), any_vec(), 4'h1, 1'b0, CONTENT_RANDOM));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, any_vec(), any_vec(), 4'hA, 1'b1,
                          CONTENT_NOISY));
      send_word(make_word(6'd33, 11'sd0, 11'sd0, 4'hA, 1'b0, CONTENT_CHECKER));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, 11'sd0, 11'sd0, 4'h5, 1'b0, CONTENT_CHECKER));
      // A vector one step outside the range leaves the fresh minima
      // untouched. The lower bound itself is accepted.
      wait_results_drained();
      write_csr(sad32_pkg::CSR_MIN_VEC_X, 11'sd0);
      send_word(make_word(sad32_pkg::LAST_SEGMENT, -11'sd1, 11'sd0, 4'h7, 1'b1, CONTENT_EQUAL));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, 11'sd0, 11'sd0, 4'h8, 1'b0, CONTENT_NOISY));
      wait_results_drained();
      write_csr(sad32_pkg::CSR_MIN_VEC_X, sad32_pkg::VEC_LOW);
   endtask

   // Runs one range setting. Short candidates at the corners and one step
   // outside each axis. Optionally one well-formed 64-word candidate.
   task automatic run_range_phase(int lo_x, int hi_x, int lo_y, int hi_y, bit with_full);
      sad32_pkg::vec_type          vx;
      sad32_pkg::vec_type          vy;
      logic [sad32_pkg::DIR_W-1:0] dir;
      content_kind_type            kind;
      wait_results_drained();
      write_csr(sad32_pkg::CSR_MIN_VEC_X, sad32_pkg::vec_type'(lo_x));
      write_csr(sad32_pkg::CSR_MAX_VEC_X, sad32_pkg::vec_type'(hi_x));
      write_csr(sad32_pkg::CSR_MIN_VEC_Y, sad32_pkg::vec_type'(lo_y));
      write_csr(sad32_pkg::CSR_MAX_VEC_Y, sad32_pkg::vec_type'(hi_y));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, sad32_pkg::vec_type'(lo_x),
                          sad32_pkg::vec_type'(lo_y), sad32_pkg::DIR_W'($urandom),
                          1'b1, content_kind_type'($urandom_range(0, 4))));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, sad32_pkg::vec_type'(hi_x),
                          sad32_pkg::vec_type'(hi_y), sad32_pkg::DIR_W'($urandom),
                          1'b0, content_kind_type'($urandom_range(0, 4))));
      // One step outside either axis wraps at the field ends. The predictor
      // follows that wrap too.
      send_word(make_word(sad32_pkg::LAST_SEGMENT, sad32_pkg::vec_type'(lo_x - 1),
                          sad32_pkg::vec_type'(hi_y), sad32_pkg::DIR_W'($urandom),
                          1'b0, CONTENT_NOISY));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, sad32_pkg::vec_type'(hi_x),
                          sad32_pkg::vec_type'(hi_y + 1), sad32_pkg::DIR_W'($urandom),
                          1'b0, CONTENT_EQUAL));
      if (with_full) begin
         vx   = vec_near_range(lo_x, hi_x);
         vy   = vec_near_range(lo_y, hi_y);
         dir  = sad32_pkg::DIR_W'($urandom);
         kind = content_kind_type'($urandom_range(0, 4));
         for (int s = 0; s < 64; s++)
            send_word(make_word(sad32_pkg::SEG_W'(s), vx, vy, dir,
                                (s == 0) && ($urandom_range(0, 1) == 1), kind));
      end
   endtask

   task automatic test_range_settings();
      run_range_phase(-8, 8, -4, 4, 1'b1);
      // An empty horizontal range rejects every candidate.
      run_range_phase(5, -5, -1024, 1023, 1'b1);
      // A single allowed point, at the opposite extremes of the two axes.
      run_range_phase(1023, 1023, -1024, -1024, 1'b1);
      // An empty vertical range.
      run_range_phase(-1024, 1023, 3, 2, 1'b0);
      run_range_phase(-1024, 1023, -1024, 1023, 1'b1);
   endtask

   // Noise: random segments, random new-block flags and random content.
   // After some closing words the sender waits until every result is back.
   task automatic test_broken_sequences();
      req_word_type w;
      for (int n = 0; n < 40; n++) begin
         w = make_word(($urandom_range(0, 7) == 0) ? sad32_pkg::LAST_SEGMENT
                                                   : sad32_pkg::SEG_W'($urandom),
                       any_vec(), any_vec(), sad32_pkg::DIR_W'($urandom),
                       ($urandom_range(0, 9) == 0),
                       content_kind_type'($urandom_range(0, 4)));
         send_word(w);
         if (w.segment == sad32_pkg::LAST_SEGMENT && $urandom_range(0, 2) == 0)
            wait_results_drained();
      end
   endtask

   // Thirty-four maximal words in the bottom-left quadrant exceed the
   // 17-bit sum. That sum must then stay at its ceiling.
   task automatic test_quadrant_saturation();
      sad32_pkg::vec_type vx;
      sad32_pkg::vec_type vy;
      wait_results_drained();
      vx = any_vec();
      vy = any_vec();
      for (int n = 0; n < 34; n++)
         send_word(make_word(sad32_pkg::SEG_W'(2 * $urandom_range(16, 31)), vx, vy, 4'hC,
                             (n == 0), CONTENT_MAX_DIFF));
      send_word(make_word(sad32_pkg::LAST_SEGMENT, vx, vy, 4'hC, 1'b0, CONTENT_MAX_DIFF));
   endtask

   // ------------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = sad32_pkg::CSR_MIN_VEC_X;
      csr_wdata  = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_range_settings();
      test_broken_sequences();
      test_quadrant_saturation();
      wait_results_drained();

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
